[hw/rtl/hbe_pkg.sv]
// ----------------------------------------------------------------------------
// hbe_pkg
// Shared types and constants of the Huffman build-and-encode block.
// ----------------------------------------------------------------------------
`default_nettype none

package hbe_pkg;

  localparam int unsigned LEAVES     = 256;
  localparam int unsigned TREE_NODES = 511;
  localparam int unsigned NODE_AW    = 9;
  localparam int unsigned SYM_W      = 8;
  localparam int unsigned PATH_MAX   = 256;
  localparam logic [7:0]  TOP_BIT    = 8'h80;

  typedef enum logic [1:0] {
    REQ_COUNT  = 2'd0,
    REQ_ENCODE = 2'd1,
    REQ_FLUSH  = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_CNT_RD, ST_CNT_WR, ST_INIT_RD, ST_INIT_WR, ST_SCAN, ST_SCAN_TAIL,
    ST_MRG_LO, ST_MRG_HI, ST_MRG_FR, ST_WALK_RD, ST_WALK_CHK, ST_POP, ST_FLUSH
  } state_e;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_LOAD, CMD_CNT_RD, CMD_CNT_WR, CMD_INIT_RD, CMD_INIT_WR, CMD_SCAN,
    CMD_SCAN_TAIL, CMD_MRG_LO, CMD_MRG_HI, CMD_MRG_FR, CMD_WALK_RD, CMD_WALK_CHK,
    CMD_POP, CMD_FLUSH
  } cmd_e;

  typedef struct packed {
    logic tree_ready;
    logic init_last;
    logic scan_last;
    logic fresh_last;
    logic walk_up;
    logic depth_zero;
    logic pop_last;
  } status_t;

endpackage

`default_nettype wire

[hw/rtl/hbe_ram.sv]
// ----------------------------------------------------------------------------
// hbe_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hbe_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

[hw/rtl/hbe_ctrl.sv]
// ----------------------------------------------------------------------------
// hbe_ctrl
// Sequencer for count, tree build, code walk, bit packing and flush.
// ----------------------------------------------------------------------------
`default_nettype none

module hbe_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire logic [1:0]       req_type_i,
  input  wire hbe_pkg::status_t status_i,
  output hbe_pkg::cmd_e         cmd_o,
  output logic                  busy
);

  hbe_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= hbe_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      hbe_pkg::ST_IDLE: begin
        if (start) begin
          unique case (hbe_pkg::req_e'(req_type_i))
            hbe_pkg::REQ_COUNT:  state_d = hbe_pkg::ST_CNT_RD;
            hbe_pkg::REQ_ENCODE: state_d = status_i.tree_ready ? hbe_pkg::ST_WALK_RD
                                                               : hbe_pkg::ST_INIT_RD;
            hbe_pkg::REQ_FLUSH:  state_d = hbe_pkg::ST_FLUSH;
            default:             state_d = hbe_pkg::ST_IDLE;
          endcase
        end
      end
      hbe_pkg::ST_CNT_RD:    state_d = hbe_pkg::ST_CNT_WR;
      hbe_pkg::ST_CNT_WR:    state_d = hbe_pkg::ST_IDLE;
      hbe_pkg::ST_INIT_RD:   state_d = hbe_pkg::ST_INIT_WR;
      hbe_pkg::ST_INIT_WR:   state_d = status_i.init_last ? hbe_pkg::ST_SCAN
                                                          : hbe_pkg::ST_INIT_RD;
      hbe_pkg::ST_SCAN:      state_d = status_i.scan_last ? hbe_pkg::ST_SCAN_TAIL
                                                          : hbe_pkg::ST_SCAN;
      hbe_pkg::ST_SCAN_TAIL: state_d = hbe_pkg::ST_MRG_LO;
      hbe_pkg::ST_MRG_LO:    state_d = hbe_pkg::ST_MRG_HI;
      hbe_pkg::ST_MRG_HI:    state_d = hbe_pkg::ST_MRG_FR;
      hbe_pkg::ST_MRG_FR:    state_d = status_i.fresh_last ? hbe_pkg::ST_WALK_RD
                                                           : hbe_pkg::ST_SCAN;
      hbe_pkg::ST_WALK_RD:   state_d = hbe_pkg::ST_WALK_CHK;
      hbe_pkg::ST_WALK_CHK: begin
        if (status_i.walk_up) begin
          state_d = hbe_pkg::ST_WALK_RD;
        end else if (status_i.depth_zero) begin
          state_d = hbe_pkg::ST_IDLE;
        end else begin
          state_d = hbe_pkg::ST_POP;
        end
      end
      hbe_pkg::ST_POP:       state_d = status_i.pop_last ? hbe_pkg::ST_IDLE : hbe_pkg::ST_POP;
      hbe_pkg::ST_FLUSH:     state_d = hbe_pkg::ST_IDLE;
      default:               state_d = hbe_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy  = (state_q != hbe_pkg::ST_IDLE);
    cmd_o = hbe_pkg::CMD_NONE;
    unique case (state_q)
      hbe_pkg::ST_IDLE:      cmd_o = start ? hbe_pkg::CMD_LOAD : hbe_pkg::CMD_NONE;
      hbe_pkg::ST_CNT_RD:    cmd_o = hbe_pkg::CMD_CNT_RD;
      hbe_pkg::ST_CNT_WR:    cmd_o = hbe_pkg::CMD_CNT_WR;
      hbe_pkg::ST_INIT_RD:   cmd_o = hbe_pkg::CMD_INIT_RD;
      hbe_pkg::ST_INIT_WR:   cmd_o = hbe_pkg::CMD_INIT_WR;
      hbe_pkg::ST_SCAN:      cmd_o = hbe_pkg::CMD_SCAN;
      hbe_pkg::ST_SCAN_TAIL: cmd_o = hbe_pkg::CMD_SCAN_TAIL;
      hbe_pkg::ST_MRG_LO:    cmd_o = hbe_pkg::CMD_MRG_LO;
      hbe_pkg::ST_MRG_HI:    cmd_o = hbe_pkg::CMD_MRG_HI;
      hbe_pkg::ST_MRG_FR:    cmd_o = hbe_pkg::CMD_MRG_FR;
      hbe_pkg::ST_WALK_RD:   cmd_o = hbe_pkg::CMD_WALK_RD;
      hbe_pkg::ST_WALK_CHK:  cmd_o = hbe_pkg::CMD_WALK_CHK;
      hbe_pkg::ST_POP:       cmd_o = hbe_pkg::CMD_POP;
      hbe_pkg::ST_FLUSH:     cmd_o = hbe_pkg::CMD_FLUSH;
      default:               cmd_o = hbe_pkg::CMD_NONE;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/hbe_datapath.sv]
// ----------------------------------------------------------------------------
// hbe_datapath
// Histogram, tree memories, merge scan, code path stack and byte packer.
// ----------------------------------------------------------------------------
`default_nettype none

module hbe_datapath #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire hbe_pkg::cmd_e    cmd_i,
  input  wire logic [7:0]       data_byte_i,
  output hbe_pkg::status_t      status_o,
  output logic                  out_valid_o,
  output logic [7:0]            out_byte_o,
  output logic                  last_o
);

  localparam int unsigned NW = COUNT_WIDTH + 1;
  localparam int unsigned PW = hbe_pkg::NODE_AW + 1;
  localparam int unsigned AW = hbe_pkg::NODE_AW;
  localparam logic [AW-1:0] FIRST_FRESH = AW'(hbe_pkg::LEAVES);
  localparam logic [AW-1:0] LAST_NODE   = AW'(hbe_pkg::TREE_NODES - 1);
  localparam logic [COUNT_WIDTH-1:0] WMAX = '1;

  logic [hbe_pkg::SYM_W-1:0]    sym_q;
  logic [hbe_pkg::LEAVES-1:0]   cvalid_q;
  logic                         tree_ready_q;
  logic [AW-1:0]                idx_q, fresh_q, cur_q;
  logic [AW-1:0]                lo_q, hi_q, rd_idx_q;
  logic [COUNT_WIDTH-1:0]       lw_q, hw_q;
  logic                         have_lo_q, have_hi_q, rd_v_q;
  logic [hbe_pkg::PATH_MAX-1:0] path_q;
  logic [AW-1:0]                depth_q;
  logic [7:0]                   pb_q;
  logic [2:0]                   pc_q;

  logic                         cnt_we, node_we, par_we;
  logic [hbe_pkg::SYM_W-1:0]    cnt_addr;
  logic [COUNT_WIDTH-1:0]       cnt_wdata, cnt_rdata, cnt_val;
  logic [AW-1:0]                node_addr, par_addr;
  logic [NW-1:0]                node_wdata, node_rdata;
  logic [PW-1:0]                par_wdata, par_rdata;
  logic [COUNT_WIDTH:0]         wsum;
  logic [COUNT_WIDTH-1:0]       rw;
  logic                         pop_bit;

  hbe_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(hbe_pkg::LEAVES)) u_cnt_ram (
    .clk_i(clk_i), .we_i(cnt_we), .addr_i(cnt_addr), .wdata_i(cnt_wdata),
    .rdata_o(cnt_rdata));

  hbe_ram #(.WIDTH(NW), .DEPTH(hbe_pkg::TREE_NODES)) u_node_ram (
    .clk_i(clk_i), .we_i(node_we), .addr_i(node_addr), .wdata_i(node_wdata),
    .rdata_o(node_rdata));

  hbe_ram #(.WIDTH(PW), .DEPTH(hbe_pkg::TREE_NODES)) u_par_ram (
    .clk_i(clk_i), .we_i(par_we), .addr_i(par_addr), .wdata_i(par_wdata),
    .rdata_o(par_rdata));

  always_comb begin
    cnt_val  = cvalid_q[cnt_addr] ? cnt_rdata : '0;
    rw       = node_rdata[COUNT_WIDTH-1:0];
    wsum     = {1'b0, lw_q} + {1'b0, hw_q};
    pop_bit  = path_q[0];
    cnt_we   = (cmd_i == hbe_pkg::CMD_CNT_WR);
    cnt_addr = sym_q;
    if (cmd_i == hbe_pkg::CMD_INIT_RD || cmd_i == hbe_pkg::CMD_INIT_WR) begin
      cnt_addr = idx_q[hbe_pkg::SYM_W-1:0];
    end
    cnt_wdata  = (cnt_val == WMAX) ? WMAX : cnt_val + COUNT_WIDTH'(1);
    node_we    = 1'b0;
    node_addr  = idx_q;
    node_wdata = '0;
    par_we     = 1'b0;
    par_addr   = cur_q;
    par_wdata  = '0;
    unique case (cmd_i)
      hbe_pkg::CMD_INIT_WR: begin
        node_we    = 1'b1;
        node_wdata = {1'b0, (idx_q < FIRST_FRESH) ? cnt_val : COUNT_WIDTH'(0)};
      end
      hbe_pkg::CMD_MRG_LO: begin
        node_we    = 1'b1;
        node_addr  = lo_q;
        node_wdata = {1'b1, lw_q};
        par_we     = 1'b1;
        par_addr   = lo_q;
        par_wdata  = {1'b0, fresh_q};
      end
      hbe_pkg::CMD_MRG_HI: begin
        node_we    = 1'b1;
        node_addr  = hi_q;
        node_wdata = {1'b1, hw_q};
        par_we     = 1'b1;
        par_addr   = hi_q;
        par_wdata  = {1'b1, fresh_q};
      end
      hbe_pkg::CMD_MRG_FR: begin
        node_we    = 1'b1;
        node_addr  = fresh_q;
        node_wdata = {1'b0, wsum[COUNT_WIDTH] ? WMAX : wsum[COUNT_WIDTH-1:0]};
      end
      hbe_pkg::CMD_WALK_RD, hbe_pkg::CMD_WALK_CHK: node_addr = cur_q;
      default: ;
    endcase
  end

  always_comb begin
    status_o.tree_ready = tree_ready_q;
    status_o.init_last  = (idx_q == LAST_NODE);
    status_o.scan_last  = (idx_q + AW'(1) == fresh_q);
    status_o.fresh_last = (fresh_q == LAST_NODE);
    status_o.walk_up    = node_rdata[COUNT_WIDTH];
    status_o.depth_zero = (depth_q == '0);
    status_o.pop_last   = (depth_q == AW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cvalid_q     <= '0;
      tree_ready_q <= 1'b0;
      pb_q         <= '0;
      pc_q         <= '0;
      out_valid_o  <= 1'b0;
      rd_v_q       <= 1'b0;
      have_lo_q    <= 1'b0;
      have_hi_q    <= 1'b0;
      depth_q      <= '0;
    end else begin
      out_valid_o <= (cmd_i == hbe_pkg::CMD_POP && pc_q == 3'd7) ||
                     (cmd_i == hbe_pkg::CMD_FLUSH && pc_q != '0);
      rd_v_q      <= (cmd_i == hbe_pkg::CMD_SCAN);
      if (rd_v_q && !node_rdata[COUNT_WIDTH]) begin
        if (!have_hi_q) begin
          have_hi_q <= 1'b1;
        end else if (!have_lo_q) begin
          have_lo_q <= 1'b1;
        end
      end
      unique case (cmd_i)
        hbe_pkg::CMD_LOAD: begin
          depth_q   <= '0;
          have_lo_q <= 1'b0;
          have_hi_q <= 1'b0;
        end
        hbe_pkg::CMD_CNT_WR: cvalid_q[sym_q] <= 1'b1;
        hbe_pkg::CMD_MRG_FR: begin
          have_lo_q <= 1'b0;
          have_hi_q <= 1'b0;
          if (fresh_q == LAST_NODE) begin
            tree_ready_q <= 1'b1;
          end
        end
        hbe_pkg::CMD_WALK_CHK: begin
          if (node_rdata[COUNT_WIDTH]) begin
            depth_q <= depth_q + AW'(1);
          end
        end
        hbe_pkg::CMD_POP: begin
          depth_q <= depth_q - AW'(1);
          pb_q    <= (pc_q == 3'd7) ? '0 : {pb_q[6:0], pop_bit};
          pc_q    <= pc_q + 3'd1;
        end
        hbe_pkg::CMD_FLUSH: begin
          cvalid_q     <= '0;
          tree_ready_q <= 1'b0;
          pb_q         <= '0;
          pc_q         <= '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q <= idx_q;
    if (rd_v_q && !node_rdata[COUNT_WIDTH]) begin
      if (!have_hi_q) begin
        hi_q <= rd_idx_q;
        hw_q <= rw;
      end else if (!have_lo_q) begin
        if (rw <= hw_q) begin
          lo_q <= rd_idx_q;
          lw_q <= rw;
        end else begin
          lo_q <= hi_q;
          lw_q <= hw_q;
          hi_q <= rd_idx_q;
          hw_q <= rw;
        end
      end else if (rw <= hw_q) begin
        if (rw >= lw_q) begin
          hi_q <= rd_idx_q;
          hw_q <= rw;
        end else begin
          hi_q <= lo_q;
          hw_q <= lw_q;
          lo_q <= rd_idx_q;
          lw_q <= rw;
        end
      end
    end
    unique case (cmd_i)
      hbe_pkg::CMD_LOAD: begin
        sym_q   <= data_byte_i ^ hbe_pkg::TOP_BIT;
        cur_q   <= {1'b0, data_byte_i ^ hbe_pkg::TOP_BIT};
        idx_q   <= '0;
        fresh_q <= FIRST_FRESH;
      end
      hbe_pkg::CMD_INIT_WR: idx_q <= (idx_q == LAST_NODE) ? '0 : idx_q + AW'(1);
      hbe_pkg::CMD_SCAN:    idx_q <= idx_q + AW'(1);
      hbe_pkg::CMD_MRG_FR: begin
        idx_q   <= '0;
        fresh_q <= fresh_q + AW'(1);
      end
      hbe_pkg::CMD_WALK_CHK: begin
        if (node_rdata[COUNT_WIDTH]) begin
          path_q <= {path_q[hbe_pkg::PATH_MAX-2:0], par_rdata[PW-1]};
          cur_q  <= par_rdata[AW-1:0];
        end
      end
      hbe_pkg::CMD_POP: begin
        path_q     <= path_q >> 1;
        out_byte_o <= {pb_q[6:0], pop_bit} ^ hbe_pkg::TOP_BIT;
        last_o     <= (depth_q <= AW'(8));
      end
      hbe_pkg::CMD_FLUSH: begin
        out_byte_o <= (pb_q << (4'd8 - {1'b0, pc_q})) ^ hbe_pkg::TOP_BIT;
        last_o     <= 1'b1;
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ($past(cmd_i) == hbe_pkg::CMD_POP || $past(cmd_i) == hbe_pkg::CMD_FLUSH))
    else $error("result strobe without pop or flush");
  a_flush_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == hbe_pkg::CMD_FLUSH |=> (!tree_ready_q && pc_q == '0 && cvalid_q == '0))
    else $error("flush left state behind");
  a_lo_hi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    have_lo_q |-> have_hi_q)
    else $error("smallest found before second-smallest");
  a_merge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i == hbe_pkg::CMD_MRG_LO |-> (have_lo_q && have_hi_q))
    else $error("merge without two candidates");
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q < AW'(hbe_pkg::PATH_MAX))
    else $error("code path overflow");
`endif

endmodule

`default_nettype wire

[hw/rtl/huffman_build_and_encode.sv]
// ----------------------------------------------------------------------------
// huffman_build_and_encode
// Two-pass byte Huffman encoder: histogram, tree build, packed code output.
//
//   channel  direction  handshake                  payload
//   request  in         start & !busy              req_type_i, data_byte_i
//   result   out        out_valid_o (one cycle)    out_byte_o, last_o
//
// Busy after the accepting edge: a count runs through CNT_RD and CNT_WR; a flush
// runs through FLUSH, its partial byte, if any, strobed in the cycle after.
// First encode after reset or flush builds the tree: a load of every node
// entry, then 255 merges, each a scan of the nodes below fresh and the MRG_LO,
// MRG_HI and MRG_FR writes, bound by the single node memory port.
// Encode: each node from leaf to root, root included, is read and checked,
// then one cycle per code bit; a byte strobes in the cycle after its last bit.
// Asynchronous active-low reset clears control state and the histogram.
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_build_and_encode #(
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] req_type_i,
  input  wire logic [7:0] data_byte_i,
  output logic            out_valid_o,
  output logic [7:0]      out_byte_o,
  output logic            last_o
);

  hbe_pkg::cmd_e    cmd;
  hbe_pkg::status_t status;

  hbe_ctrl u_ctrl (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .req_type_i(req_type_i),
    .status_i(status), .cmd_o(cmd), .busy(busy));

  hbe_datapath #(.COUNT_WIDTH(COUNT_WIDTH)) u_dp (
    .clk_i(clk_i), .rst_ni(rst_ni), .cmd_i(cmd), .data_byte_i(data_byte_i),
    .status_o(status), .out_valid_o(out_valid_o), .out_byte_o(out_byte_o),
    .last_o(last_o));

endmodule

`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Huffman build-and-encode block.
//
// Requests are sent in jobs: count bytes, encode bytes, then flush. The bench
// predicts each job alongside the block: it keeps the histogram, builds the
// same tree with the same tie order, walks each code and packs bytes. Every
// result is checked against the oldest prediction. The directed jobs cover
// byte extremes, the unused request code, an empty histogram, counts after the
// build, encodes with no full byte and flushes with and without a partial
// byte. The random jobs follow, with varying gaps on the request side.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb;

  localparam int CW          = 32;
  localparam int CYCLE_LIMIT = 5000000;
  localparam int MAX_SHOWN   = 10;

  typedef struct {
    logic [7:0] code_byte;
    logic       last;
  } code_out_t;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic [1:0] req_type_i;
  logic [7:0] data_byte_i;
  logic       out_valid_o;
  logic [7:0] out_byte_o;
  logic       last_o;

  huffman_build_and_encode #(.COUNT_WIDTH(CW)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_type_i  (req_type_i),
    .data_byte_i (data_byte_i),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

  logic [CW-1:0] hist       [hbe_pkg::LEAVES];
  logic [CW-1:0] node_wgt   [hbe_pkg::TREE_NODES];
  logic [8:0]    node_up    [hbe_pkg::TREE_NODES];
  bit            node_linked[hbe_pkg::TREE_NODES];
  bit            node_bit   [hbe_pkg::TREE_NODES];
  bit            tree_built;
  logic [7:0]    pack_bits;
  logic [2:0]    pack_cnt;

  code_out_t code_q[$];
  int        mismatches;
  int        results_seen;
  int        reqs_sent;
  int        jobs_done;
  int        cycles;
  int        idle_pct;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  function automatic void clear_model();
    for (int i = 0; i < hbe_pkg::LEAVES; i++) hist[i] = '0;
    for (int i = 0; i < hbe_pkg::TREE_NODES; i++) node_linked[i] = 1'b0;
    tree_built = 1'b0;
    pack_bits  = '0;
    pack_cnt   = '0;
  endfunction

  function automatic void build_code_tree();
    int lo;
    int hi;
    logic [CW:0] sum;
    for (int i = 0; i < hbe_pkg::TREE_NODES; i++) begin
      node_linked[i] = 1'b0;
      node_wgt[i]    = (i < hbe_pkg::LEAVES) ? hist[i] : '0;
    end
    for (int fresh = hbe_pkg::LEAVES; fresh < hbe_pkg::TREE_NODES; fresh++) begin
      lo = -1;
      hi = -1;
      for (int i = 0; i < fresh; i++) begin
        if (node_linked[i]) continue;
        if (hi < 0) begin
          hi = i;
        end else if (lo < 0) begin
          if (node_wgt[i] <= node_wgt[hi]) begin
            lo = i;
          end else begin
            lo = hi;
            hi = i;
          end
        end else if (node_wgt[i] <= node_wgt[hi]) begin
          if (node_wgt[i] >= node_wgt[lo]) begin
            hi = i;
          end else begin
            hi = lo;
            lo = i;
          end
        end
      end
      if (lo < 0 || hi < 0) break;
      node_bit[lo]    = 1'b0;
      node_bit[hi]    = 1'b1;
      node_up[lo]     = fresh[8:0];
      node_up[hi]     = fresh[8:0];
      node_linked[lo] = 1'b1;
      node_linked[hi] = 1'b1;
      sum = {1'b0, node_wgt[lo]} + {1'b0, node_wgt[hi]};
      node_wgt[fresh] = sum[CW] ? {CW{1'b1}} : sum[CW-1:0];
    end
    tree_built = 1'b1;
  endfunction

  function automatic void predict_codes(hbe_pkg::req_e req, logic [7:0] data);
    code_out_t outs[$];
    code_out_t one;
    bit        path[hbe_pkg::TREE_NODES];
    int        depth;
    int        node;
    logic [7:0] sym;
    sym   = data ^ hbe_pkg::TOP_BIT;
    depth = 0;
    case (req)
      hbe_pkg::REQ_COUNT: begin
        if (hist[sym] != {CW{1'b1}}) hist[sym] = hist[sym] + CW'(1);
      end
      hbe_pkg::REQ_ENCODE: begin
        if (!tree_built) build_code_tree();
        node = int'(sym);
        while (depth < hbe_pkg::TREE_NODES && node_linked[node]) begin
          path[depth] = node_bit[node];
          depth++;
          node = int'(node_up[node]);
        end
        for (int k = depth - 1; k >= 0; k--) begin
          pack_bits = {pack_bits[6:0], path[k]};
          pack_cnt  = pack_cnt + 3'd1;
          if (pack_cnt == 3'd0) begin
            one.code_byte = pack_bits ^ hbe_pkg::TOP_BIT;
            one.last      = 1'b0;
            if (outs.size() < 32) outs.push_back(one);
            pack_bits = '0;
          end
        end
      end
      hbe_pkg::REQ_FLUSH: begin
        if (pack_cnt != 3'd0) begin
          one.code_byte = (pack_bits << (4'd8 - {1'b0, pack_cnt})) ^ hbe_pkg::TOP_BIT;
          one.last      = 1'b0;
          outs.push_back(one);
        end
        clear_model();
      end
      default: ;
    endcase
    if (outs.size() > 0) outs[outs.size() - 1].last = 1'b1;
    foreach (outs[i]) code_q.push_back(outs[i]);
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o) begin
      results_seen <= results_seen + 1;
      if (code_q.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < MAX_SHOWN)
          $display("unexpected result byte=%02h last=%b", out_byte_o, last_o);
      end else begin
        if (out_byte_o !== code_q[0].code_byte || last_o !== code_q[0].last) begin
          mismatches <= mismatches + 1;
          if (mismatches < MAX_SHOWN)
            $display("mismatch: expected byte=%02h last=%b, got byte=%02h last=%b",
                     code_q[0].code_byte, code_q[0].last, out_byte_o, last_o);
        end
        void'(code_q.pop_front());
      end
    end
  end

  task automatic send_req(hbe_pkg::req_e req, logic [7:0] data);
    start       <= 1'b1;
    req_type_i  <= req;
    data_byte_i <= data;
    do @(posedge clk_i); while (busy);
    predict_codes(req, data);
    reqs_sent++;
    if (req == hbe_pkg::REQ_FLUSH) jobs_done++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
  endtask

  task automatic drain_codes();
    start <= 1'b0;
    while (code_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_empty_histogram();
    send_req(hbe_pkg::REQ_ENCODE, 8'h80);
    send_req(hbe_pkg::REQ_ENCODE, 8'h7F);
    send_req(hbe_pkg::REQ_ENCODE, 8'h00);
    send_req(hbe_pkg::REQ_ENCODE, 8'hFF);
    send_req(hbe_pkg::REQ_FLUSH, 8'h00);
    send_req(hbe_pkg::REQ_FLUSH, 8'hA5);
  endtask

  task automatic test_directed_codes();
    send_req(hbe_pkg::REQ_COUNT, 8'h00);
    send_req(hbe_pkg::REQ_COUNT, 8'hFF);
    send_req(hbe_pkg::REQ_COUNT, 8'h80);
    send_req(hbe_pkg::REQ_COUNT, 8'h80);
    send_req(hbe_pkg::REQ_COUNT, 8'h7F);
    send_req(hbe_pkg::REQ_COUNT, 8'h55);
    send_req(hbe_pkg::REQ_NONE, 8'hAA);
    send_req(hbe_pkg::REQ_ENCODE, 8'h80);
    send_req(hbe_pkg::REQ_ENCODE, 8'h00);
    send_req(hbe_pkg::REQ_COUNT, 8'h00);
    send_req(hbe_pkg::REQ_ENCODE, 8'hFF);
    send_req(hbe_pkg::REQ_ENCODE, 8'h7F);
    send_req(hbe_pkg::REQ_ENCODE, 8'h55);
    send_req(hbe_pkg::REQ_ENCODE, 8'h12);
    drain_codes();
    send_req(hbe_pkg::REQ_FLUSH, 8'hFF);
  endtask

  task automatic test_random_jobs(int pct, int jobs);
    logic [7:0] alphabet[16];
    logic [7:0] data[$];
    int         n;
    idle_pct = pct;
    for (int j = 0; j < jobs; j++) begin
      n = $urandom_range(3, 16);
      for (int a = 0; a < 16; a++) alphabet[a] = 8'($urandom_range(0, 255));
      data.delete();
      for (int i = 0; i < 17; i++) begin
        data.push_back(alphabet[$urandom_range(0, n - 1) >> $urandom_range(0, 2)]);
        if ($urandom_range(9) == 0)
          send_req(hbe_pkg::REQ_NONE, 8'($urandom_range(0, 255)));
        send_req(hbe_pkg::REQ_COUNT, data[i]);
      end
      foreach (data[i]) begin
        if ($urandom_range(11) == 0)
          send_req(hbe_pkg::REQ_COUNT, 8'($urandom_range(0, 255)));
        if ($urandom_range(11) == 0)
          send_req(hbe_pkg::REQ_ENCODE, 8'($urandom_range(0, 255)));
        else send_req(hbe_pkg::REQ_ENCODE, data[i]);
      end
      if (j == 0) drain_codes();
      send_req(hbe_pkg::REQ_FLUSH, 8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst_ni       = 1'b0;
    start        = 1'b0;
    req_type_i   = hbe_pkg::REQ_NONE;
    data_byte_i  = '0;
    mismatches   = 0;
    results_seen = 0;
    reqs_sent    = 0;
    jobs_done    = 0;
    cycles       = 0;
    idle_pct     = 6;
    clear_model();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_histogram();
    test_directed_codes();
    test_random_jobs(6, 2);
    test_random_jobs(66, 2);
    test_random_jobs(0, 2);

    drain_codes();
    repeat (50) @(posedge clk_i);
    $display("covered %0d requests in %0d jobs, %0d code bytes checked",
             reqs_sent, jobs_done, results_seen);
    $display("mismatches: %0d, predictions left: %0d", mismatches, code_q.size());
    if (mismatches == 0 && code_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

[sim.f]
hw/rtl/hbe_pkg.sv
hw/rtl/hbe_ram.sv
hw/rtl/hbe_ctrl.sv
hw/rtl/hbe_datapath.sv
hw/rtl/huffman_build_and_encode.sv
verif/tb.sv
